@@ hdl/dgr_pkg.sv @@
package dgr_pkg;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_REACH = 2'd1,
    ACT_NODE  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_NQ_RD,
    ST_NQ_DATA,
    ST_RCH_START,
    ST_RCH,
    ST_OUT
  } state_t;

  localparam logic [6:0]  NODE_COUNT_RESET = 7'd64;
  localparam logic [15:0] REPORT_MAX       = 16'd255;

endpackage

@@ hdl/dependency_graph_reachability.sv @@
// Channel  Handshake              Word
// in       in_valid / in_ready    in_action, in_source_node, in_dest_node
// out      out_valid / out_ready  out_reachable, out_edge_added, out_child_count,
//                                 out_parent_count, out_is_root_node
// cfg      cfg_valid / cfg_ready  cfg_data (node_count)
//
// A clear goes from idle straight to the output state, a node query through
// NQ_RD and NQ_DATA, an add through ADD_RD and ADD_WR; the last step of each
// is the move of the result into the output register. A reach query passes
// RCH_START, then scans: one adjacency row is read per cycle from the single
// row memory port, and the scan pointer steps round all NODES nodes per pass.
// Reset is synchronous; per-row valid bits clear the graph at once, with no sweep.
// in_ready is high only when idle; a word waiting at the output does not stop
// the next input word being taken.
module dependency_graph_reachability #(
  parameter int NODES      = 64,
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [5:0]        in_source_node,
  input  logic signed [7:0] in_dest_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_reachable,
  output logic              out_edge_added,
  output logic [7:0]        out_child_count,
  output logic [7:0]        out_parent_count,
  output logic              out_is_root_node,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);

  localparam int IDX_W = $clog2(NODES);
  localparam logic [8:0]       NODES9   = 9'(NODES);
  localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(NODES - 1);
  localparam logic [NODES-1:0] ONE      = NODES'(1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  dgr_pkg::state_t state_r, state_nxt;
  logic [6:0]       node_count_r;
  logic [IDX_W-1:0] src_r, src_nxt, dst_r, dst_nxt, ptr_r, ptr_nxt;
  logic [NODES-1:0] visit_r, visit_nxt, pend_r, pend_nxt;
  logic             fly_r, fly_nxt;

  logic             res_reach_r, res_reach_nxt, res_edge_r, res_edge_nxt;
  logic             res_root_r, res_root_nxt;
  logic [7:0]       res_child_r, res_child_nxt, res_parent_r, res_parent_nxt;
  logic             out_valid_r, out_valid_nxt, out_load;

  logic [NODES-1:0] adj_mem [NODES];
  logic [COUNT_BITS-1:0] succ_mem [NODES];
  logic [COUNT_BITS-1:0] pred_mem [NODES];
  logic [NODES-1:0] adj_vld_r, succ_vld_r, pred_vld_r;

  logic [NODES-1:0] adj_q_r, adj_wdata, row;
  logic [COUNT_BITS-1:0] succ_q_r, pred_q_r, succ_val, pred_val;
  logic             adj_qv_r, succ_qv_r, pred_qv_r;
  logic [IDX_W-1:0] adj_raddr, pred_raddr;
  logic             adj_we, succ_we, pred_we, clr, issue;
  logic [15:0]      succ16, pred16;

  logic [7:0] src8;
  logic [8:0] dst9;
  logic       src_ok, dst_in, add_ok;

  assign src8   = {2'b00, in_source_node};
  assign dst9   = {2'b00, in_dest_node[6:0]};
  assign src_ok = {1'b0, src8} < NODES9;
  assign dst_in = !in_dest_node[7] && (dst9 < NODES9);
  assign add_ok = dst_in && (dst9 < {2'b00, node_count_r});

  assign row      = (fly_r && adj_qv_r) ? adj_q_r : '0;
  assign succ_val = succ_qv_r ? succ_q_r : '0;
  assign pred_val = pred_qv_r ? pred_q_r : '0;
  assign succ16   = 16'(succ_val);
  assign pred16   = 16'(pred_val);
  assign issue    = pend_r[ptr_r];

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    ptr_nxt        = ptr_r;
    visit_nxt      = visit_r;
    pend_nxt       = pend_r;
    fly_nxt        = fly_r;
    res_reach_nxt  = res_reach_r;
    res_edge_nxt   = res_edge_r;
    res_root_nxt   = res_root_r;
    res_child_nxt  = res_child_r;
    res_parent_nxt = res_parent_r;
    in_ready       = 1'b0;
    adj_raddr      = src_r;
    pred_raddr     = dst_r;
    adj_wdata      = row | (ONE << dst_r);
    adj_we         = 1'b0;
    succ_we        = 1'b0;
    pred_we        = 1'b0;
    clr            = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      dgr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          src_nxt        = src8[IDX_W-1:0];
          dst_nxt        = dst9[IDX_W-1:0];
          res_reach_nxt  = 1'b0;
          res_edge_nxt   = 1'b0;
          res_root_nxt   = 1'b0;
          res_child_nxt  = '0;
          res_parent_nxt = '0;
          state_nxt      = dgr_pkg::ST_OUT;
          case (in_action)
            dgr_pkg::ACT_ADD: begin
              if (src_ok && add_ok) state_nxt = dgr_pkg::ST_ADD_RD;
            end
            dgr_pkg::ACT_REACH: begin
              if (src_ok && dst_in) state_nxt = dgr_pkg::ST_RCH_START;
            end
            dgr_pkg::ACT_NODE: begin
              if (src_ok) state_nxt = dgr_pkg::ST_NQ_RD;
              else res_root_nxt = 1'b1;
            end
            default: begin
              clr = 1'b1;
            end
          endcase
        end
      end
      dgr_pkg::ST_ADD_RD: begin
        fly_nxt   = 1'b1;
        state_nxt = dgr_pkg::ST_ADD_WR;
      end
      dgr_pkg::ST_ADD_WR: begin
        adj_we       = 1'b1;
        succ_we      = 1'b1;
        pred_we      = 1'b1;
        res_edge_nxt = 1'b1;
        fly_nxt      = 1'b0;
        state_nxt    = dgr_pkg::ST_OUT;
      end
      dgr_pkg::ST_NQ_RD: begin
        pred_raddr = src_r;
        state_nxt  = dgr_pkg::ST_NQ_DATA;
      end
      dgr_pkg::ST_NQ_DATA: begin
        res_child_nxt  = (succ16 > dgr_pkg::REPORT_MAX) ? 8'hFF : succ16[7:0];
        res_parent_nxt = (pred16 > dgr_pkg::REPORT_MAX) ? 8'hFF : pred16[7:0];
        res_root_nxt   = (pred16 == 16'd0);
        state_nxt      = dgr_pkg::ST_OUT;
      end
      dgr_pkg::ST_RCH_START: begin
        visit_nxt = '0;
        pend_nxt  = '0;
        ptr_nxt   = '0;
        fly_nxt   = 1'b1;
        state_nxt = dgr_pkg::ST_RCH;
      end
      dgr_pkg::ST_RCH: begin
        adj_raddr = ptr_r;
        visit_nxt = visit_r | row;
        pend_nxt  = (pend_r & ~(issue ? (ONE << ptr_r) : '0)) | (row & ~visit_r);
        fly_nxt   = issue;
        ptr_nxt   = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        if (visit_nxt[dst_r]) begin
          res_reach_nxt = 1'b1;
          fly_nxt       = 1'b0;
          state_nxt     = dgr_pkg::ST_OUT;
        end else if (pend_nxt == '0 && !issue) begin
          res_reach_nxt = 1'b0;
          state_nxt     = dgr_pkg::ST_OUT;
        end
      end
      dgr_pkg::ST_OUT: begin
        fly_nxt = 1'b0;
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = dgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dgr_pkg::ST_IDLE;
      end
    endcase
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dgr_pkg::ST_IDLE;
      node_count_r <= dgr_pkg::NODE_COUNT_RESET;
      out_valid_r  <= 1'b0;
      fly_r        <= 1'b0;
      adj_vld_r    <= '0;
      succ_vld_r   <= '0;
      pred_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fly_r       <= fly_nxt;
      if (cfg_valid && cfg_ready) node_count_r <= cfg_data;
      if (clr) begin
        adj_vld_r  <= '0;
        succ_vld_r <= '0;
        pred_vld_r <= '0;
      end else begin
        if (adj_we)  adj_vld_r[src_r]  <= 1'b1;
        if (succ_we) succ_vld_r[src_r] <= 1'b1;
        if (pred_we) pred_vld_r[dst_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    ptr_r        <= ptr_nxt;
    visit_r      <= visit_nxt;
    pend_r       <= pend_nxt;
    res_reach_r  <= res_reach_nxt;
    res_edge_r   <= res_edge_nxt;
    res_root_r   <= res_root_nxt;
    res_child_r  <= res_child_nxt;
    res_parent_r <= res_parent_nxt;
    adj_qv_r     <= adj_vld_r[adj_raddr];
    succ_qv_r    <= succ_vld_r[src_r];
    pred_qv_r    <= pred_vld_r[pred_raddr];
    if (out_load) begin
      out_reachable    <= res_reach_r;
      out_edge_added   <= res_edge_r;
      out_child_count  <= res_child_r;
      out_parent_count <= res_parent_r;
      out_is_root_node <= res_root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[src_r] <= adj_wdata;
    adj_q_r <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (succ_we) succ_mem[src_r] <= (succ_val == CMAX) ? succ_val : succ_val + 1'b1;
    succ_q_r <= succ_mem[src_r];
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[dst_r] <= (pred_val == CMAX) ? pred_val : pred_val + 1'b1;
    pred_q_r <= pred_mem[pred_raddr];
  end

endmodule

@@ tb/dgr_result_monitor.sv @@
module dgr_result_monitor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [5:0]        in_source_node,
  input  logic signed [7:0] in_dest_node,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_reachable,
  input  logic              out_edge_added,
  input  logic [7:0]        out_child_count,
  input  logic [7:0]        out_parent_count,
  input  logic              out_is_root_node,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [6:0]        cfg_data,
  output int                failures,
  output int                pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       reachable;
    logic       edge_added;
    logic [7:0] child_count;
    logic [7:0] parent_count;
    logic       is_root_node;
  } graph_result_t;

  logic [63:0]   adj_rows [64];
  logic [7:0]    child_tally [64];
  logic [7:0]    parent_tally [64];
  logic [6:0]    node_limit;
  graph_result_t awaited_results [$];

  initial begin
    failures = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $realtime, msg);
    failures++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic void clear_graph();
    for (int n = 0; n < 64; n++) begin
      adj_rows[n] = '0;
      child_tally[n] = '0;
      parent_tally[n] = '0;
    end
  endfunction

  function automatic logic path_exists(logic [5:0] start, logic [5:0] target);
    logic [63:0] seen;
    logic [63:0] wave;
    logic [63:0] grown;
    seen = adj_rows[start];
    wave = seen;
    while (wave != '0 && !seen[target]) begin
      grown = '0;
      for (int n = 0; n < 64; n++) begin
        if (wave[n]) grown |= adj_rows[n];
      end
      wave = grown & ~seen;
      seen |= wave;
    end
    return seen[target];
  endfunction

  function automatic graph_result_t apply_word(dgr_pkg::action_t act, logic [5:0] src,
                                               logic [7:0] dst);
    graph_result_t r;
    logic [6:0] span;
    r = '0;
    span = (node_limit > 7'd64) ? 7'd64 : node_limit;
    case (act)
      dgr_pkg::ACT_ADD: begin
        if (!dst[7] && dst[6:0] < span) begin
          adj_rows[src][dst[5:0]] = 1'b1;
          if (child_tally[src] != 8'hFF) child_tally[src]++;
          if (parent_tally[dst[5:0]] != 8'hFF) parent_tally[dst[5:0]]++;
          r.edge_added = 1'b1;
        end
      end
      dgr_pkg::ACT_REACH: begin
        if (!dst[7] && dst[6:0] < 7'd64) r.reachable = path_exists(src, dst[5:0]);
      end
      dgr_pkg::ACT_NODE: begin
        r.child_count = child_tally[src];
        r.parent_count = parent_tally[src];
        r.is_root_node = (parent_tally[src] == 8'd0);
      end
      default: begin
        clear_graph();
      end
    endcase
    return r;
  endfunction

  // A result word is checked before the input word accepted at the same edge is applied.
  always @(posedge clk) begin
    graph_result_t want;
    if (!rst_n) begin
      clear_graph();
      node_limit = dgr_pkg::NODE_COUNT_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("reachable", 8'(out_reachable), 8'(want.reachable));
          check_field("edge_added", 8'(out_edge_added), 8'(want.edge_added));
          check_field("child_count", out_child_count, want.child_count);
          check_field("parent_count", out_parent_count, want.parent_count);
          check_field("is_root_node", 8'(out_is_root_node), 8'(want.is_root_node));
        end
      end
      if (cfg_valid && cfg_ready) node_limit = cfg_data;
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_word(dgr_pkg::action_t'(in_action), in_source_node,
                                             in_dest_node));
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic [5:0]        in_source_node;
  logic signed [7:0] in_dest_node;
  logic              out_valid;
  logic              out_ready;
  logic              out_reachable;
  logic              out_edge_added;
  logic [7:0]        out_child_count;
  logic [7:0]        out_parent_count;
  logic              out_is_root_node;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [6:0]        cfg_data;
  int                failures;
  int                pending_results;
  bit                steady = 1'b0;

  logic [6:0] limit_plan [8] = '{7'd40, 7'd8, 7'd1, 7'd127, 7'd0, 7'd64, 7'd20, 7'd64};

  dependency_graph_reachability dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_source_node(in_source_node), .in_dest_node(in_dest_node),
    .out_valid(out_valid), .out_ready(out_ready), .out_reachable(out_reachable),
    .out_edge_added(out_edge_added), .out_child_count(out_child_count),
    .out_parent_count(out_parent_count), .out_is_root_node(out_is_root_node),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  dgr_result_monitor result_monitor (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_source_node(in_source_node), .in_dest_node(in_dest_node),
    .out_valid(out_valid), .out_ready(out_ready), .out_reachable(out_reachable),
    .out_edge_added(out_edge_added), .out_child_count(out_child_count),
    .out_parent_count(out_parent_count), .out_is_root_node(out_is_root_node),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .failures(failures), .pending_results(pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_word(dgr_pkg::action_t act, logic [5:0] src, logic [7:0] dst);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action <= act;
    in_source_node <= src;
    in_dest_node <= dst;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_node_count(logic [6:0] value);
    drain_and_settle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word(int pool);
    int pick;
    dgr_pkg::action_t act;
    logic [5:0] src;
    logic [7:0] dst;
    pick = $urandom_range(0, 99);
    act = pick < 45 ? dgr_pkg::ACT_ADD :
          pick < 75 ? dgr_pkg::ACT_REACH :
          pick < 98 ? dgr_pkg::ACT_NODE : dgr_pkg::ACT_CLEAR;
    src = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, pool - 1));
    dst = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, pool - 1));
    send_word(act, src, dst);
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [5:0] prev;
    logic [5:0] hop;
    int pool;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = dgr_pkg::ACT_ADD;
    in_source_node = '0;
    in_dest_node = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(dgr_pkg::ACT_NODE, 6'd0, 8'd0);
    send_word(dgr_pkg::ACT_ADD, 6'd0, 8'd1);
    send_word(dgr_pkg::ACT_ADD, 6'd1, 8'd2);
    send_word(dgr_pkg::ACT_ADD, 6'd2, 8'd0);
    send_word(dgr_pkg::ACT_ADD, 6'd0, 8'd1);
    send_word(dgr_pkg::ACT_ADD, 6'd63, 8'd63);
    send_word(dgr_pkg::ACT_ADD, 6'd5, 8'hFF);
    send_word(dgr_pkg::ACT_ADD, 6'd5, 8'h80);
    send_word(dgr_pkg::ACT_ADD, 6'd5, 8'h7F);
    send_word(dgr_pkg::ACT_ADD, 6'd5, 8'd64);
    send_word(dgr_pkg::ACT_REACH, 6'd0, 8'd0);
    send_word(dgr_pkg::ACT_REACH, 6'd3, 8'd3);
    send_word(dgr_pkg::ACT_REACH, 6'd63, 8'd63);
    send_word(dgr_pkg::ACT_REACH, 6'd0, 8'd2);
    send_word(dgr_pkg::ACT_REACH, 6'd2, 8'd1);
    send_word(dgr_pkg::ACT_REACH, 6'd1, 8'hFB);
    send_word(dgr_pkg::ACT_REACH, 6'd0, 8'd64);
    send_word(dgr_pkg::ACT_REACH, 6'd4, 8'd0);
    send_word(dgr_pkg::ACT_NODE, 6'd0, 8'd0);
    send_word(dgr_pkg::ACT_NODE, 6'd1, 8'd0);
    send_word(dgr_pkg::ACT_NODE, 6'd63, 8'd0);
    send_word(dgr_pkg::ACT_NODE, 6'd5, 8'd0);
    send_word(dgr_pkg::ACT_CLEAR, 6'd0, 8'd0);
    send_word(dgr_pkg::ACT_NODE, 6'd1, 8'd0);
    send_word(dgr_pkg::ACT_REACH, 6'd0, 8'd1);

    set_node_count(dgr_pkg::NODE_COUNT_RESET);
    repeat (260) send_word(dgr_pkg::ACT_ADD, 6'd7, 8'd9);
    send_word(dgr_pkg::ACT_NODE, 6'd7, 8'd0);
    send_word(dgr_pkg::ACT_NODE, 6'd9, 8'd0);
    send_word(dgr_pkg::ACT_REACH, 6'd7, 8'd9);

    for (int phase = 0; phase < 8; phase++) begin
      set_node_count(limit_plan[phase]);
      steady = (phase % 3 == 2);
      pool = limit_plan[phase] < 7'd2 ? 16 :
             limit_plan[phase] > 7'd64 ? 64 : int'(limit_plan[phase]);
      prev = 6'($urandom_range(0, pool - 1));
      for (int k = 0; k < 12; k++) begin
        hop = 6'($urandom_range(0, pool - 1));
        send_word(dgr_pkg::ACT_ADD, prev, {2'b00, hop});
        prev = hop;
      end
      repeat (70) random_word(pool);
    end

    drain_and_settle();
    repeat (64 * 64 + 8) @(negedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/dgr_pkg.sv
hdl/dependency_graph_reachability.sv
tb/dgr_result_monitor.sv
tb/testbench.sv
